>>> rtl/tbud_pkg.sv
// ----------------------------------------------------------------------------
// tbud_pkg: shared types and constants for the text byte decoder
// Request kinds, decode modes, held-byte state and per-item step result.
// ----------------------------------------------------------------------------
package tbud_pkg;

    typedef enum logic [1:0] {
        REQ_DATA  = 2'd0,
        REQ_END   = 2'd1,
        REQ_TABLE = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_TABLE   = 2'd0,
        MODE_U16_HI  = 2'd1,
        MODE_U16_LO  = 2'd2,
        MODE_UTF8    = 2'd3
    } mode_t;

    localparam logic [15:0] BAD_SEQ = 16'hFEFF;
    localparam int          MAP_DEPTH = 256;

    // bytes held of an unfinished sequence
    typedef struct packed {
        logic [1:0] pending;
        logic [7:0] first;
        logic [7:0] second;
    } hold_t;

    // outcome of one request
    typedef struct packed {
        logic        emit;       // request produces a result
        logic        use_table;  // code point comes from the charset map
        logic        last;       // end-of-text marker
        logic [15:0] cp;         // code point (map index when use_table)
    } step_res_t;

endpackage

>>> rtl/text_byte_to_unicode_decoder.sv
// ----------------------------------------------------------------------------
// text_byte_to_unicode_decoder: byte stream to 16-bit code point decoder
// Charset-table, UTF-16 (either byte order) and UTF-8 decoding of a byte
// stream, one request per cycle unless m_axis stalls, with an end-of-text marker.
// ----------------------------------------------------------------------------
//
//  channel   | signals                         | contents
//  ----------+---------------------------------+-------------------------------
//  s_axis    | tvalid tready tdata[31:0] tuser | request: byte / table write,
//            |                                 | tuser = request kind
//  m_axis    | tvalid tready tdata[15:0] tlast | code point, tlast = end marker
//  cfg       | cfg_wr_en cfg_wr_data[1:0]      | decode mode
//
// One request per cycle sustained while m_axis does not stall; a request passes
// the middle stage (decode + charset RAM read), then the output register.
// The charset RAM read port sets the stage split: its data is registered.
// Reset clears the held bytes, the mode and all map-written flags at once;
// an unwritten map entry reads as its own index, so no clearing pass.
// Stalls on m_axis back up through the middle stage; s_axis keeps taking
// requests while the output register holds a result and the middle is free.
// ----------------------------------------------------------------------------
module text_byte_to_unicode_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] data_byte, [15:8] table_index,
                                        // [31:16] table_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_point
    output logic        m_axis_tlast,   // end_of_text

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data     // decode_mode
);

    localparam int MAP_AW = $clog2(tbud_pkg::MAP_DEPTH);

    // input field split
    logic [7:0]        data_byte;
    logic [7:0]        table_index;
    logic [15:0]       table_value;
    tbud_pkg::req_t    req_type;

    assign data_byte   = s_axis_tdata[7:0];
    assign table_index = s_axis_tdata[15:8];
    assign table_value = s_axis_tdata[31:16];
    assign req_type    = tbud_pkg::req_t'(s_axis_tuser);

    // state
    tbud_pkg::mode_t     mode_reg;
    tbud_pkg::hold_t     hold_reg;
    tbud_pkg::hold_t     hold_next;
    tbud_pkg::step_res_t step_res;
    logic [tbud_pkg::MAP_DEPTH-1:0] written_reg;

    // middle stage (waiting on charset RAM data)
    logic                s1_v_reg;
    tbud_pkg::step_res_t s1_res_reg;
    logic                s1_hit_reg;
    logic [15:0]         map_q;
    logic [15:0]         s1_cp;

    // output register
    logic                out_v_reg;
    logic [15:0]         out_cp_reg;
    logic                out_last_reg;

    logic accept;
    logic out_free;
    logic s1_move;
    logic map_we;
    logic map_re;

    // ---- decode step ----
    tbud_step u_step (
        .mode      (mode_reg),
        .hold      (hold_reg),
        .req_type  (req_type),
        .data_byte (data_byte),
        .hold_next (hold_next),
        .res       (step_res)
    );

    // ---- handshake ----
    assign out_free      = !out_v_reg || m_axis_tready;
    assign s1_move       = s1_v_reg && out_free;
    assign s_axis_tready = !s1_v_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---- charset map ----
    assign map_we = accept && (req_type == tbud_pkg::REQ_TABLE);
    assign map_re = accept && step_res.use_table;

    tbud_ram #(
        .WIDTH (16),
        .DEPTH (tbud_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (table_index[MAP_AW-1:0]),
        .wdata (table_value),
        .re    (map_re),
        .raddr (data_byte[MAP_AW-1:0]),
        .rdata (map_q)
    );

    // unwritten entry reads as identity
    assign s1_cp = (s1_res_reg.use_table && s1_hit_reg) ? map_q : s1_res_reg.cp;

    // ---- mode, held bytes, written flags ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= tbud_pkg::MODE_TABLE;
            hold_reg    <= '0;
            written_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                // mode change drops any partial sequence
                mode_reg <= tbud_pkg::mode_t'(cfg_wr_data);
                hold_reg <= '0;
            end
            else if (accept)
            begin
                hold_reg <= hold_next;
            end
            if (map_we)
            begin
                written_reg[table_index[MAP_AW-1:0]] <= 1'b1;
            end
        end
    end

    // ---- middle stage ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_v_reg <= step_res.emit;
        end
        else if (s1_move)
        begin
            s1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= step_res;
            s1_hit_reg <= written_reg[data_byte[MAP_AW-1:0]];
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_cp_reg   <= s1_cp;
            out_last_reg <= s1_res_reg.last;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_cp_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // end marker always carries a zero code point
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == 16'h0000))
        else $error("end marker with nonzero code point");

    // end of text leaves nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == tbud_pkg::REQ_END && !cfg_wr_en) |=> (hold_reg.pending == 2'd0))
        else $error("pending bytes survived end of text");

    // a second held byte only exists in UTF-8
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_reg.pending == 2'd2) |-> (mode_reg == tbud_pkg::MODE_UTF8))
        else $error("two bytes held outside UTF-8");

    // full pipe with stalled output must not take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && out_v_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken into full pipe");

    // a waiting middle result moves once the output frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && out_free && !accept) |=> out_v_reg)
        else $error("middle result lost");
`endif

endmodule

>>> rtl/tbud_ram.sv
// ----------------------------------------------------------------------------
// tbud_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tbud_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/tbud_step.sv
// ----------------------------------------------------------------------------
// tbud_step: one-request decode step
// Given held bytes, mode and a request, gives the next held state and result.
// ----------------------------------------------------------------------------
module tbud_step (
    input  tbud_pkg::mode_t     mode,
    input  tbud_pkg::hold_t     hold,
    input  tbud_pkg::req_t      req_type,
    input  logic [7:0]          data_byte,
    output tbud_pkg::hold_t     hold_next,
    output tbud_pkg::step_res_t res
);

    localparam tbud_pkg::hold_t HOLD_CLEAR = '0;

    always_comb
    begin
        hold_next = hold;
        res       = '0;
        case (req_type)
            tbud_pkg::REQ_DATA:
            begin
                case (mode)
                    tbud_pkg::MODE_TABLE:
                    begin
                        res.emit      = 1'b1;
                        res.use_table = 1'b1;
                        res.cp        = {8'h00, data_byte};
                    end
                    tbud_pkg::MODE_U16_HI, tbud_pkg::MODE_U16_LO:
                    begin
                        if (hold.pending == 2'd0)
                        begin
                            hold_next.first   = data_byte;
                            hold_next.pending = 2'd1;
                        end
                        else
                        begin
                            res.emit  = 1'b1;
                            res.cp    = (mode == tbud_pkg::MODE_U16_HI) ?
                                        {hold.first, data_byte} :
                                        {data_byte, hold.first};
                            hold_next = HOLD_CLEAR;
                        end
                    end
                    default:
                    begin
                        // UTF-8
                        if (hold.pending == 2'd0)
                        begin
                            if (data_byte < 8'h80)
                            begin
                                res.emit = 1'b1;
                                res.cp   = {8'h00, data_byte};
                            end
                            else if (data_byte inside {[8'h80:8'hBF], [8'hF0:8'hFF]})
                            begin
                                // stray continuation, four-byte lead or F8-FF byte
                                res.emit = 1'b1;
                                res.cp   = tbud_pkg::BAD_SEQ;
                            end
                            else
                            begin
                                hold_next.first   = data_byte;
                                hold_next.pending = 2'd1;
                            end
                        end
                        else if (hold.first < 8'hE0)
                        begin
                            res.emit  = 1'b1;
                            res.cp    = {5'b00000, hold.first[4:0], data_byte[5:0]};
                            hold_next = HOLD_CLEAR;
                        end
                        else if (hold.pending == 2'd1)
                        begin
                            hold_next.second  = data_byte;
                            hold_next.pending = 2'd2;
                        end
                        else
                        begin
                            res.emit  = 1'b1;
                            res.cp    = {hold.first[3:0], hold.second[5:0], data_byte[5:0]};
                            hold_next = HOLD_CLEAR;
                        end
                    end
                endcase
            end
            tbud_pkg::REQ_END:
            begin
                res.emit  = 1'b1;
                res.last  = 1'b1;
                hold_next = HOLD_CLEAR;
            end
            default:
            begin
                // table writes and unused kinds leave the held bytes alone
            end
        endcase
    end

endmodule

>>> verif/text_byte_to_unicode_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_byte_to_unicode_decoder_test: self-checking bench for the byte decoder
// A short table of directed requests covers every mode, the field extremes and
// the corner cases. Randomized phases follow, one decode mode per phase, most with
// bursty idling on the streams. A local decoder model tracks the charset map
// and held bytes and predicts each code point, which is checked as it comes out.
// ----------------------------------------------------------------------------
module text_byte_to_unicode_decoder_test;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;         // drain margin after the last owed code point
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_REQS    = 133;
    localparam int HOLD_CYCLES   = 150;       // long sink hold-off, fills the pipe
    localparam int MAX_REPORTS   = 40;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int NUM_DIR       = 27;

    // one decoded character as it leaves the block
    typedef struct packed {
        logic [15:0] cp;
        logic        eot;
    } cp_item_t;

    // directed request; cp/eot are used only when typed is set
    typedef struct packed {
        tbud_pkg::mode_t mode;
        tbud_pkg::req_t  kind;
        logic [7:0]      data;
        logic [7:0]      idx;
        logic [15:0]     val;
        logic            typed;
        logic [15:0]     cp;
        logic            eot;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // charset table: identity after reset, then loaded entries
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_DATA, 8'h00, 8'h00, 16'h0, 1'b1, 16'h0000, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_DATA, 8'hFF, 8'h00, 16'h0, 1'b1, 16'h00FF, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_NONE, 8'hFF, 8'h41, 16'hFFFF, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_TABLE, 8'h00, 8'h41, 16'hFFFF, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_DATA, 8'h41, 8'h00, 16'h0, 1'b1, 16'hFFFF, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_TABLE, 8'h00, 8'hFF, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_DATA, 8'hFF, 8'h00, 16'h0, 1'b1, 16'h0000, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_END, 8'h00, 8'h00, 16'h0, 1'b1, 16'h0000, 1'b1},
        // UTF-16, first byte high; end of text drops a half pair
        '{tbud_pkg::MODE_U16_HI, tbud_pkg::REQ_DATA, 8'h12, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_U16_HI, tbud_pkg::REQ_DATA, 8'h34, 8'h00, 16'h0, 1'b1, 16'h1234, 1'b0},
        '{tbud_pkg::MODE_U16_HI, tbud_pkg::REQ_DATA, 8'hAB, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_U16_HI, tbud_pkg::REQ_END, 8'h00, 8'h00, 16'h0, 1'b1, 16'h0000, 1'b1},
        // UTF-16, first byte low
        '{tbud_pkg::MODE_U16_LO, tbud_pkg::REQ_DATA, 8'h12, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_U16_LO, tbud_pkg::REQ_DATA, 8'h34, 8'h00, 16'h0, 1'b1, 16'h3412, 1'b0},
        // UTF-8: ASCII top, stray continuation, bad lead, 2- and 3-byte forms
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'h7F, 8'h00, 16'h0, 1'b1, 16'h007F, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'h80, 8'h00, 16'h0, 1'b1, 16'hFEFF, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hF0, 8'h00, 16'h0, 1'b1, 16'hFEFF, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hC3, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hA9, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hE2, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        // table write in mid sequence keeps the held bytes
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_TABLE, 8'h00, 8'h10, 16'h1234, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'h82, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hAC, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hEF, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_END, 8'h00, 8'h00, 16'h0, 1'b1, 16'h0000, 1'b1},
        // held lead, then a mode write must drop it
        '{tbud_pkg::MODE_UTF8, tbud_pkg::REQ_DATA, 8'hE1, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0},
        '{tbud_pkg::MODE_TABLE, tbud_pkg::REQ_DATA, 8'h10, 8'h00, 16'h0, 1'b0, 16'h0, 1'b0}
    };

    localparam tbud_pkg::mode_t MODE_ORDER [4] = '{
        tbud_pkg::MODE_U16_HI, tbud_pkg::MODE_U16_LO, tbud_pkg::MODE_UTF8, tbud_pkg::MODE_TABLE
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [7:0] data_byte, [15:8] table_index, [31:16] table_value
    logic [1:0]  s_axis_tuser;    // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [15:0] code_point
    logic        m_axis_tlast;    // end_of_text
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;

    // decoder model state
    logic [15:0]     map_model [tbud_pkg::MAP_DEPTH];
    tbud_pkg::mode_t mode_now;
    logic [1:0]      held_cnt;
    logic [7:0]      held_first;
    logic [7:0]      held_second;

    cp_item_t    code_point_q [$];    // code points still owed by the block
    int          bad_cnt   = 0;
    int          req_cnt   = 0;       // requests that do something
    int          gap_pct   = 0;       // source idle chance per request
    int          stall_pct = 0;       // sink stall chance per cycle
    bit          hold_out  = 1'b0;    // asks the sink for one long hold-off

    text_byte_to_unicode_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS)
            $display("ERROR at %0t: %s: want %h got %h", $time, what, want, got);
    endtask

    function automatic void drop_held();
        held_cnt    = 2'd0;
        held_first  = 8'h00;
        held_second = 8'h00;
    endfunction

    // Advance the model by one request; returns 1 when a character comes out.
    function automatic logic decode_request(input tbud_pkg::req_t kind,
                                            input logic [7:0] b,
                                            input logic [7:0] idx, input logic [15:0] val,
                                            output cp_item_t res);
        logic hit;
        hit = 1'b0;
        res = '0;
        case (kind)
            tbud_pkg::REQ_DATA:
            begin
                case (mode_now)
                    tbud_pkg::MODE_TABLE:
                    begin
                        res.cp = map_model[b];
                        hit    = 1'b1;
                    end
                    tbud_pkg::MODE_U16_HI, tbud_pkg::MODE_U16_LO:
                    begin
                        if (held_cnt == 2'd0)
                        begin
                            held_first = b;
                            held_cnt   = 2'd1;
                        end
                        else
                        begin
                            res.cp = (mode_now == tbud_pkg::MODE_U16_HI) ? {held_first, b}
                                                                         : {b, held_first};
                            drop_held();
                            hit = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (held_cnt == 2'd0)
                        begin
                            if (b < 8'h80)
                            begin
                                res.cp = {8'h00, b};
                                hit    = 1'b1;
                            end
                            else if (b < 8'hC0 || b >= 8'hF0)
                            begin
                                res.cp = tbud_pkg::BAD_SEQ;
                                hit    = 1'b1;
                            end
                            else
                            begin
                                held_first = b;
                                held_cnt   = 2'd1;
                            end
                        end
                        else if (held_first < 8'hE0)
                        begin
                            res.cp = {5'd0, held_first[4:0], b[5:0]};
                            drop_held();
                            hit = 1'b1;
                        end
                        else if (held_cnt == 2'd1)
                        begin
                            held_second = b;
                            held_cnt    = 2'd2;
                        end
                        else
                        begin
                            res.cp = {held_first[3:0], held_second[5:0], b[5:0]};
                            drop_held();
                            hit = 1'b1;
                        end
                    end
                endcase
            end
            tbud_pkg::REQ_END:
            begin
                drop_held();
                res.eot = 1'b1;
                hit     = 1'b1;
            end
            tbud_pkg::REQ_TABLE: map_model[idx] = val;
            default: ;
        endcase
        return hit;
    endfunction

    // Offer one request (entered and left at a falling edge).
    task automatic send_req(input tbud_pkg::req_t kind, input logic [7:0] b,
                            input logic [7:0] idx, input logic [15:0] val,
                            input logic typed, input cp_item_t fixed);
        cp_item_t res;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, idx, b};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (decode_request(kind, b, idx, val, res))
            code_point_q.push_back(typed ? fixed : res);
        if (kind != tbud_pkg::REQ_NONE)
            req_cnt++;
        @(negedge clk);
    endtask

    // index and value fields get random content
    task automatic send_rand(input tbud_pkg::req_t kind, input logic [7:0] b);
        send_req(kind, b, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 1'b0, '0);
    endtask

    function automatic logic [7:0] any_byte(input int lo, input int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // Mostly well-formed UTF-8, with stray, bad and cut-off sequences, table writes and ends mixed in.
    task automatic send_utf8_chunk();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h00, 8'h7F));
        else if (r < 55)
        begin
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'hC0, 8'hDF));
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h80, 8'hBF));
        end
        else if (r < 80)
        begin
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'hE0, 8'hEF));
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h80, 8'hBF));
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h80, 8'hBF));
        end
        else if (r < 86)
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h80, 8'hBF));
        else if (r < 90)
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'hF0, 8'hFF));
        else if (r < 94)
        begin
            // cut-off sequence: lead, maybe any byte, then maybe an end
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'hC0, 8'hEF));
            if ($urandom_range(0, 1) == 0)
                send_rand(tbud_pkg::REQ_DATA, any_byte(8'h00, 8'hFF));
            if ($urandom_range(0, 1) == 0)
                send_rand(tbud_pkg::REQ_END, 8'h00);
        end
        else if (r < 97)
            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h00, 8'hFF));
        else if (r < 99)
            send_rand(tbud_pkg::REQ_TABLE, 8'h00);
        else
            send_rand(tbud_pkg::REQ_END, 8'h00);
    endtask

    // Let the block drain: no code point owed, and no byte still in flight.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (code_point_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input tbud_pkg::mode_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_now = m;
        drop_held();
    endtask

    // check each code point as it is taken by the sink
    always @(posedge clk)
    begin : check_results
        cp_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (code_point_q.size() == 0)
                flag_mismatch("code point with none owed", 16'h0000, m_axis_tdata);
            else
            begin
                want = code_point_q.pop_front();
                if (m_axis_tdata !== want.cp)
                    flag_mismatch("code point", want.cp, m_axis_tdata);
                if (m_axis_tlast !== want.eot)
                    flag_mismatch("end marker", {15'd0, want.eot}, {15'd0, m_axis_tlast});
            end
        end
    end

    // sink: random stall bursts, plus one long hold-off on request
    initial
    begin : result_sink
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int              p;
        int              r;
        int              phase_start;
        bit              quiet;
        tbud_pkg::mode_t phase_mode;
        cp_item_t        fixed;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tbud_pkg::REQ_DATA;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = tbud_pkg::MODE_TABLE;
        for (p = 0; p < tbud_pkg::MAP_DEPTH; p++)
            map_model[p] = 16'(p);
        mode_now = tbud_pkg::MODE_TABLE;
        drop_held();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table; mode changes only once the block has drained
        gap_pct   = 20;
        stall_pct = 20;
        for (p = 0; p < NUM_DIR; p++)
        begin
            if (DIR_ROWS[p].mode != mode_now)
            begin
                wait_idle();
                write_mode(DIR_ROWS[p].mode);
            end
            fixed.cp  = DIR_ROWS[p].cp;
            fixed.eot = DIR_ROWS[p].eot;
            send_req(DIR_ROWS[p].kind, DIR_ROWS[p].data, DIR_ROWS[p].idx, DIR_ROWS[p].val,
                     DIR_ROWS[p].typed, fixed);
        end

        // random phases, one mode each; the last ones run without idling
        for (p = 0; p < NUM_PHASES; p++)
        begin
            phase_mode = (p < 4) ? MODE_ORDER[p] : tbud_pkg::mode_t'($urandom_range(0, 3));
            wait_idle();
            write_mode(phase_mode);
            quiet = (p >= NUM_PHASES - 2);
            if (quiet || p == 1 || $urandom_range(0, 3) == 0)
                gap_pct = 0;
            else
                gap_pct = $urandom_range(5, 30);
            if (quiet || $urandom_range(0, 3) == 0)
                stall_pct = 0;
            else
                stall_pct = $urandom_range(5, 30);
            // sink holds off while the source keeps pushing, to back up the input
            if (p == 1)
                hold_out = 1'b1;
            phase_start = req_cnt;
            while (req_cnt - phase_start < PHASE_REQS)
            begin
                r = $urandom_range(0, 99);
                case (phase_mode)
                    tbud_pkg::MODE_UTF8:
                        send_utf8_chunk();
                    tbud_pkg::MODE_TABLE:
                    begin
                        if (r < 80)
                            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h00, 8'hFF));
                        else if (r < 92)
                            send_rand(tbud_pkg::REQ_TABLE, 8'h00);
                        else if (r < 96)
                            send_rand(tbud_pkg::REQ_END, 8'h00);
                        else
                            send_rand(tbud_pkg::REQ_NONE, any_byte(8'h00, 8'hFF));
                    end
                    default:
                    begin
                        if (r < 88)
                            send_rand(tbud_pkg::REQ_DATA, any_byte(8'h00, 8'hFF));
                        else if (r < 93)
                            send_rand(tbud_pkg::REQ_END, 8'h00);
                        else if (r < 97)
                            send_rand(tbud_pkg::REQ_TABLE, 8'h00);
                        else
                            send_rand(tbud_pkg::REQ_NONE, any_byte(8'h00, 8'hFF));
                    end
                endcase
            end
        end

        wait_idle();
        if (bad_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
